// File: hdl/tbs_pkg.sv
// Shared types and constants for the bilinear texture sampler.
package tbs_pkg;

    localparam int MAX_DIM         = 256;
    localparam int MAX_TEXELS      = 65536;
    localparam int COORD_FRAC_BITS = 16;

    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int TEXEL_W  = 4 * CHAN_W;
    localparam int OUT_W    = 16;
    localparam int DIM_W    = $clog2(MAX_DIM) + 1;
    localparam int POS_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = $clog2(MAX_TEXELS);
    localparam int PROD_W   = COORD_FRAC_BITS + DIM_W;
    localparam int WGT_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH   = 3'd0,
        REG_TEX_HEIGHT  = 3'd1,
        REG_HAS_ALPHA   = 3'd2,
        REG_WRAP_REPEAT = 3'd3,
        REG_BILINEAR_ON = 3'd4
    } cfg_reg_t;

    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             has_alpha;
        logic             wrap_repeat;
        logic             bilinear_on;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] index;
        logic [TEXEL_W-1:0] texel;
        logic [PROD_W-1:0]  prod_u;
        logic [PROD_W-1:0]  prod_v;
    } entry_t;

endpackage

// File: hdl/bilinear_texture_sampler_core.sv
// Top level of the bilinear texture sampler: configuration registers and the two ends.
//
// One transaction is taken per cycle while busy is low. Each passes the front
// register, the queue and back-end stage 1. A texel write then lands in the store and
// gives no result. A sample goes on through stages 2 to 4 and gives its result with
// done, in order. The receiver cannot stall and must take the result in that cycle.
// The four neighbour fetches come from four texel store copies, each read once a
// cycle, and the blend is two registered multiply stages, so throughput is one sample
// a cycle while busy is low. Texels are undefined until written; nothing clears them.
module bilinear_texture_sampler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [tbs_pkg::INDEX_W-1:0]        texel_index,
    input  logic [tbs_pkg::CHAN_W-1:0]         in_red,
    input  logic [tbs_pkg::CHAN_W-1:0]         in_green,
    input  logic [tbs_pkg::CHAN_W-1:0]         in_blue,
    input  logic [tbs_pkg::CHAN_W-1:0]         in_alpha,
    input  logic [tbs_pkg::COORD_W-1:0]        coord_u,
    input  logic [tbs_pkg::COORD_W-1:0]        coord_v,
    input  logic                               cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               done,
    output logic [tbs_pkg::OUT_W-1:0]          out_red,
    output logic [tbs_pkg::OUT_W-1:0]          out_green,
    output logic [tbs_pkg::OUT_W-1:0]          out_blue,
    output logic [tbs_pkg::OUT_W-1:0]          out_alpha
);
    import tbs_pkg::*;

    cfg_t             cfg_reg;
    logic [DIM_W-1:0] size_eff;
    logic             accept;
    logic             front_valid;
    entry_t           front_entry;
    logic             queue_full;
    logic             queue_valid;
    entry_t           queue_entry;

    // Clamp a size write to 1..MAX_DIM.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            size_eff = DIM_W'(1);
        end
        else if (DIM_W'(cfg_data) > DIM_W'(MAX_DIM))
        begin
            size_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            size_eff = DIM_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width       <= DIM_W'(MAX_DIM);
            cfg_reg.height      <= DIM_W'(MAX_DIM);
            cfg_reg.has_alpha   <= 1'b1;
            cfg_reg.wrap_repeat <= 1'b1;
            cfg_reg.bilinear_on <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:   cfg_reg.width       <= size_eff;
                REG_TEX_HEIGHT:  cfg_reg.height      <= size_eff;
                REG_HAS_ALPHA:   cfg_reg.has_alpha   <= cfg_data[0];
                REG_WRAP_REPEAT: cfg_reg.wrap_repeat <= cfg_data[0];
                REG_BILINEAR_ON: cfg_reg.bilinear_on <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign busy   = queue_full;
    assign accept = start && !busy;

    tbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cfg        (cfg_reg),
        .action     (action),
        .texel_index(texel_index),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .valid      (front_valid),
        .entry      (front_entry)
    );

    tbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_entry(front_entry),
        .full      (queue_full),
        .pop_valid (queue_valid),
        .pop_entry (queue_entry)
    );

    tbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (queue_valid),
        .entry    (queue_entry),
        .done     (done),
        .out_red  (out_red),
        .out_green(out_green),
        .out_blue (out_blue),
        .out_alpha(out_alpha)
    );

endmodule

// File: hdl/tbs_ram.sv
// Single write port, single registered read port memory.
module tbs_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tbs_front.sv
// Front end: accepts transactions and scales coordinate fractions by texture size.
module tbs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  tbs_pkg::cfg_t                 cfg,
    input  logic                          action,
    input  logic [tbs_pkg::INDEX_W-1:0]   texel_index,
    input  logic [tbs_pkg::CHAN_W-1:0]    in_red,
    input  logic [tbs_pkg::CHAN_W-1:0]    in_green,
    input  logic [tbs_pkg::CHAN_W-1:0]    in_blue,
    input  logic [tbs_pkg::CHAN_W-1:0]    in_alpha,
    input  logic [tbs_pkg::COORD_W-1:0]   coord_u,
    input  logic [tbs_pkg::COORD_W-1:0]   coord_v,
    output logic                          valid,
    output tbs_pkg::entry_t               entry
);
    import tbs_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;
    entry_t entry_next;

    // The integer part of the coordinate is a whole number of texture sizes, so
    // only the fraction times the size matters for position and weight.
    always_comb
    begin
        entry_next.action = action;
        entry_next.index  = texel_index;
        entry_next.texel  = {in_alpha, in_blue, in_green, in_red};
        entry_next.prod_u = PROD_W'(coord_u[COORD_FRAC_BITS-1:0]) * PROD_W'(cfg.width);
        entry_next.prod_v = PROD_W'(coord_v[COORD_FRAC_BITS-1:0]) * PROD_W'(cfg.height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// File: hdl/tbs_queue.sv
// Short queue between front and back ends.
module tbs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tbs_pkg::entry_t push_entry,
    output logic            full,
    output logic            pop_valid,
    output tbs_pkg::entry_t pop_entry
);
    import tbs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    // The back end never stalls, so the head leaves every cycle it is present.
    assign do_pop  = (count_reg != '0);
    assign do_push = push && (count_reg != CNT_W'(QUEUE_DEPTH) || do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = do_pop;
    assign pop_entry = slots[rd_ptr_reg];

endmodule

// File: hdl/tbs_back.sv
// Back end: neighbour addressing, texel store and bilinear blend.
module tbs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbs_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  tbs_pkg::entry_t             entry,
    output logic                        done,
    output logic [tbs_pkg::OUT_W-1:0]   out_red,
    output logic [tbs_pkg::OUT_W-1:0]   out_green,
    output logic [tbs_pkg::OUT_W-1:0]   out_blue,
    output logic [tbs_pkg::OUT_W-1:0]   out_alpha
);
    import tbs_pkg::*;

    localparam int MUL_W = (ADDR_W > 2 * DIM_W) ? ADDR_W : 2 * DIM_W;
    localparam int TOP_W = 2 * CHAN_W;
    localparam int SUM_W = TOP_W + WGT_W + 1;

    // Stage 1: neighbour positions and store addresses
    logic [POS_W-1:0]  x0;
    logic [POS_W-1:0]  y0;
    logic [DIM_W-1:0]  x1;
    logic [DIM_W-1:0]  y1;
    logic              x_edge;
    logic              y_edge;
    logic [DIM_W-1:0]  x1_w;
    logic [DIM_W-1:0]  y1_w;
    logic [MUL_W-1:0]  row0;
    logic [MUL_W-1:0]  row1;
    logic [ADDR_W-1:0] addr_next [4];

    logic               s1_valid_reg;
    logic               s1_write_reg;
    logic [ADDR_W-1:0]  s1_waddr_reg;
    logic [TEXEL_W-1:0] s1_wdata_reg;
    logic [ADDR_W-1:0]  s1_addr_reg [4];
    logic [WGT_W-1:0]   s1_tu_reg;
    logic [WGT_W-1:0]   s1_tv_reg;
    logic               s1_oobx_reg;
    logic               s1_ooby_reg;

    always_comb
    begin
        x0     = entry.prod_u[COORD_FRAC_BITS +: POS_W];
        y0     = entry.prod_v[COORD_FRAC_BITS +: POS_W];
        x1     = DIM_W'(x0) + 1'b1;
        y1     = DIM_W'(y0) + 1'b1;
        x_edge = (x1 == cfg.width);
        y_edge = (y1 == cfg.height);
        x1_w   = x_edge ? '0 : x1;
        y1_w   = y_edge ? '0 : y1;
        row0   = MUL_W'(y0) * MUL_W'(cfg.width);
        row1   = MUL_W'(y1_w) * MUL_W'(cfg.width);
        addr_next[0] = ADDR_W'(row0 + MUL_W'(x0));
        addr_next[1] = ADDR_W'(row0 + MUL_W'(x1_w));
        addr_next[2] = ADDR_W'(row1 + MUL_W'(x0));
        addr_next[3] = ADDR_W'(row1 + MUL_W'(x1_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_write_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid && (entry.action == ACTION_SAMPLE);
            s1_write_reg <= in_valid && (entry.action == ACTION_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_waddr_reg <= ADDR_W'(entry.index);
        s1_wdata_reg <= entry.texel;
        for (int i = 0; i < 4; i++)
        begin
            s1_addr_reg[i] <= addr_next[i];
        end
        // Nearest mode is a blend with both weights held at zero.
        s1_tu_reg   <= cfg.bilinear_on ? entry.prod_u[COORD_FRAC_BITS-WGT_W +: WGT_W] : '0;
        s1_tv_reg   <= cfg.bilinear_on ? entry.prod_v[COORD_FRAC_BITS-WGT_W +: WGT_W] : '0;
        s1_oobx_reg <= !cfg.wrap_repeat && x_edge;
        s1_ooby_reg <= !cfg.wrap_repeat && y_edge;
    end

    // Stage 2: one store copy per neighbour, all written together
    logic [TEXEL_W-1:0] rdata [4];
    logic               s2_valid_reg;
    logic [WGT_W-1:0]   s2_tu_reg;
    logic [WGT_W-1:0]   s2_tv_reg;
    logic               s2_oobx_reg;
    logic               s2_ooby_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        tbs_ram #(
            .DEPTH(MAX_TEXELS),
            .WIDTH(TEXEL_W)
        ) u_ram (
            .clk  (clk),
            .we   (s1_write_reg),
            .waddr(s1_waddr_reg),
            .wdata(s1_wdata_reg),
            .raddr(s1_addr_reg[g]),
            .rdata(rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tu_reg   <= s1_tu_reg;
        s2_tv_reg   <= s1_tv_reg;
        s2_oobx_reg <= s1_oobx_reg;
        s2_ooby_reg <= s1_ooby_reg;
    end

    // Stage 3: border masking, alpha fill and horizontal lerp
    logic [CHAN_W-1:0] texel [4][4];
    logic [WGT_W:0]    tu_inv;
    logic [TOP_W-1:0]  top_next [4];
    logic [TOP_W-1:0]  bot_next [4];

    logic              s3_valid_reg;
    logic [TOP_W-1:0]  s3_top_reg [4];
    logic [TOP_W-1:0]  s3_bot_reg [4];
    logic [WGT_W-1:0]  s3_tv_reg;

    always_comb
    begin
        tu_inv = (WGT_W + 1)'(1 << WGT_W) - (WGT_W + 1)'(s2_tu_reg);
        for (int n = 0; n < 4; n++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                texel[n][c] = rdata[n][CHAN_W*c +: CHAN_W];
                if (c == 3 && !cfg.has_alpha)
                begin
                    texel[n][c] = '1;
                end
                if (((n == 1 || n == 3) && s2_oobx_reg) || ((n == 2 || n == 3) && s2_ooby_reg))
                begin
                    texel[n][c] = '0;
                end
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            top_next[c] = TOP_W'(TOP_W'(texel[0][c]) * TOP_W'(tu_inv)
                                + TOP_W'(texel[1][c]) * TOP_W'(s2_tu_reg));
            bot_next[c] = TOP_W'(TOP_W'(texel[2][c]) * TOP_W'(tu_inv)
                                + TOP_W'(texel[3][c]) * TOP_W'(s2_tu_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            s3_top_reg[c] <= top_next[c];
            s3_bot_reg[c] <= bot_next[c];
        end
        s3_tv_reg <= s2_tv_reg;
    end

    // Stage 4: vertical lerp, round half up to 8 fraction bits
    logic [WGT_W:0]   tv_inv;
    logic [SUM_W-1:0] sum [4];
    logic [OUT_W-1:0] res_next [4];
    logic             done_reg;
    logic [OUT_W-1:0] res_reg [4];

    always_comb
    begin
        tv_inv = (WGT_W + 1)'(1 << WGT_W) - (WGT_W + 1)'(s3_tv_reg);
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = SUM_W'(s3_top_reg[c]) * SUM_W'(tv_inv)
                   + SUM_W'(s3_bot_reg[c]) * SUM_W'(s3_tv_reg)
                   + SUM_W'(1 << (WGT_W - 1));
            res_next[c] = sum[c][WGT_W +: OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            res_reg[c] <= res_next[c];
        end
    end

    assign done      = done_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];

endmodule
